// File: design/mhf_pkg.sv
// Shared constants, types and CRC helpers for the multicast hash filter.
package mhf_pkg;

  localparam int MacW      = 48;
  localparam int MacBytes  = MacW / 8;
  localparam int IdxW      = 6;
  localparam int WordW     = 32;
  localparam int FiltW     = 2 * WordW;
  localparam int InTdataW  = MacW;
  localparam int OutPayW   = IdxW + 2 * WordW;
  localparam int OutTdataW = ((OutPayW + 7) / 8) * 8;

  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic CmdClear = 1'b0;
  localparam logic CmdAdd   = 1'b1;

  // Filter update request from the pipeline to the filter store.
  typedef struct packed {
    logic            add;
    logic [IdxW-1:0] index;
  } filt_upd_t;

  // Advance the CRC by one octet, least significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  octet);
    logic [31:0] crc;
    logic        fb;
    crc = crc_in;
    for (int b = 0; b < 8; b++) begin
      fb  = crc[31] ^ octet[b];
      crc = {crc[30:0], 1'b0} ^ (fb ? CrcPoly : 32'h0);
    end
    return crc;
  endfunction

  function automatic logic [WordW-1:0] swap_bytes(input logic [WordW-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// File: design/mhf_hash.sv
// CRC-32 hash of one MAC address, reduced to the six-bit filter index.
module mhf_hash (
  input  logic [mhf_pkg::MacW-1:0] mac,
  output logic [mhf_pkg::IdxW-1:0] index
);
  import mhf_pkg::*;

  logic [31:0] crc_chain [MacBytes+1];

  assign crc_chain[0] = CrcInit;

  // One XOR stage per octet, first transmitted octet in the top bits.
  for (genvar i = 0; i < MacBytes; i++) begin : g_byte
    assign crc_chain[i+1] = crc_byte(crc_chain[i], mac[MacW-1-8*i -: 8]);
  end

  assign index = crc_chain[MacBytes][31 -: IdxW];

endmodule

// File: design/mhf_filter.sv
// 64-bit filter store with clear/add update and byte-swapped word view.
module mhf_filter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       upd_en,
  input  mhf_pkg::filt_upd_t         upd,
  output logic [mhf_pkg::WordW-1:0]  first_word,
  output logic [mhf_pkg::WordW-1:0]  second_word
);
  import mhf_pkg::*;

  logic [FiltW-1:0] filter_r;
  logic [FiltW-1:0] filter_nxt;

  always_comb begin
    if (upd.add) begin
      filter_nxt = filter_r | (FiltW'(1) << upd.index);
    end else begin
      filter_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= '0;
    end else if (upd_en) begin
      filter_r <= filter_nxt;
    end
  end

  // Words reflect the filter after this update.
  assign first_word  = swap_bytes(filter_nxt[FiltW-1:WordW]);
  assign second_word = swap_bytes(filter_nxt[WordW-1:0]);

endmodule

// File: design/multicast_hash_filter.sv
// Top level of the multicast CRC-32 hash filter builder.
// Each input transaction either clears the 64-bit multicast hash filter
// (tuser = 0) or adds the MAC address in tdata (tuser = 1). An added address
// is hashed with the Ethernet CRC-32 (start all ones, LSB first per octet,
// no final inversion); the top six CRC bits select the filter bit to set.
// Every input transaction yields exactly one output transaction carrying
// the index (0 on clear) and both filter halves byte-swapped as register
// words, reflecting the filter after that update. The block takes one
// transaction per clock cycle while out_tready is high. There are two
// register stages: the input register, then the CRC network and filter
// update feeding the output register. A result moves from the input
// register to the output register once that is free or draining. The input
// stalls only while both stages hold a transaction and out_tready is low.
// The filter is cleared by reset.
module multicast_hash_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mhf_pkg::InTdataW-1:0]    in_tdata,   // [47:0] mac_address
  input  logic                            in_tuser,   // [0] command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [5:0] hash_index, [37:6] first_register_word,
  // [69:38] second_register_word, [71:70] zero
  output logic [mhf_pkg::OutTdataW-1:0]   out_tdata
);
  import mhf_pkg::*;

  // Input stage
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic              s1_cmd_r;
  logic [MacW-1:0]   s1_mac_r;

  // Output stage
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [OutTdataW-1:0] out_data_r;

  logic            advance;
  logic            in_fire;
  logic [IdxW-1:0] hash_idx;
  filt_upd_t       upd;
  logic [WordW-1:0] first_word;
  logic [WordW-1:0] second_word;

  // Move the input stage forward when the output register is free or draining.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture payload on accept; no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_tuser;
      s1_mac_r <= in_tdata;
    end
  end

  mhf_hash u_hash (
    .mac   (s1_mac_r),
    .index (hash_idx)
  );

  // A clear reports index zero.
  assign upd.add   = (s1_cmd_r == CmdAdd);
  assign upd.index = upd.add ? hash_idx : '0;

  mhf_filter u_filter (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd_en      (advance),
    .upd         (upd),
    .first_word  (first_word),
    .second_word (second_word)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {(OutTdataW - OutPayW)'(0), second_word, first_word, upd.index};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: design/mhf_checker.sv
// Port-level checker for the multicast hash filter, bound to the top level.
module mhf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [mhf_pkg::OutTdataW-1:0] out_tdata
);
  import mhf_pkg::*;

  logic [IdxW-1:0]  chk_idx;
  logic [FiltW-1:0] chk_filter;

  assign chk_idx    = out_tdata[IdxW-1:0];
  assign chk_filter = {swap_bytes(out_tdata[IdxW +: WordW]),
                       swap_bytes(out_tdata[IdxW+WordW +: WordW])};

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  // Drop output valid after reset.
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Keep the padding bits zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OutTdataW-1:OutPayW] == '0)
    else $error("output padding not zero");

  // A nonzero reported index must be set in the reported filter.
  a_idx_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (chk_idx != '0) |-> chk_filter[chk_idx])
    else $error("reported index not set in filter words");

endmodule

bind multicast_hash_filter mhf_checker u_mhf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
